/* rtl/fps_pkg.sv */
// Package for the false-position root search block.
// Shared widths, status and action codes, and the controller/datapath structs.
// No dependencies.
package fps_pkg;

  localparam int DataW    = 32;              // Q16.16 word
  localparam int IterW    = 16;              // iteration counter
  localparam int TolW     = 31;              // tolerance register
  localparam int DenW     = DataW + 1;       // denominator magnitude
  localparam int ProdW    = 2 * DataW;       // product magnitude, dividend
  localparam int XW       = ProdW + 2;       // left endpoint minus quotient
  localparam int InDataW  = 5 * DataW;       // left, right, both values, sample
  localparam int OutDataW = DataW + IterW;   // point, iteration
  localparam int CfgDataW = TolW;
  localparam int DivStepsC = 2;              // quotient bits per divider cycle

  localparam logic [TolW-1:0]  TolResetC = TolW'(1);
  localparam logic [IterW-1:0] LimResetC = IterW'(100);

  typedef enum logic [2:0] {
    ST_PROPOSE   = 3'd0,
    ST_CONVERGED = 3'd1,
    ST_BAD_ORDER = 3'd2,
    ST_NO_SIGN   = 3'd3,
    ST_ZERO_DEN  = 3'd4,
    ST_LIMIT     = 3'd5,
    ST_IDLE_OVF  = 3'd6
  } status_t;

  typedef enum logic {
    ACT_START  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef enum logic {
    CFG_TOLERANCE  = 1'b0,
    CFG_ITER_LIMIT = 1'b1
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;        // latch the input transfer
    logic    clr_iter;       // start item: clear the iteration count
    logic    load_bracket;   // start item: take the new bracket
    logic    update_bracket; // sample item: move one endpoint
    logic    prep;           // register operand magnitudes
    logic    div_start;      // multiply and launch the divider
    logic    calc_x;         // form the new point
    logic    finish;         // commit the proposal
    logic    stop;           // end the search
    logic    res_load;       // load the pending result
    status_t res_code;
    logic    res_zero;       // result point is zero
    logic    emit;           // move the pending result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic bad_order;
    logic no_sign;
    logic searching;
    logic converged;
    logic limit_hit;
    logic den_zero;
    logic div_done;
    logic overflow;
    logic out_free;
  } sts_t;

endpackage

/* rtl/fps_div.sv */
// Iterative unsigned divider for the false-position datapath.
// Restoring division, fps_pkg::DivStepsC quotient bits per cycle. Uses fps_pkg.
module fps_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fps_pkg::ProdW-1:0]  dividend,
  input  logic [fps_pkg::DenW-1:0]   divisor,
  output logic                       done,
  output logic [fps_pkg::ProdW-1:0]  quotient
);

  localparam int Cycles = fps_pkg::ProdW / fps_pkg::DivStepsC;
  localparam int CntW   = $clog2(Cycles);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic [fps_pkg::DenW-1:0]  rem_r, rem_nxt;
  logic [fps_pkg::DenW-1:0]  den_r, den_nxt;
  logic [fps_pkg::ProdW-1:0] quo_r, quo_nxt;
  logic [fps_pkg::DenW:0]    r;
  logic [fps_pkg::ProdW-1:0] q;

  always_comb begin
    r = {1'b0, rem_r};
    q = quo_r;
    for (int i = 0; i < fps_pkg::DivStepsC; i++) begin
      r = {r[fps_pkg::DenW-1:0], q[fps_pkg::ProdW-1]};
      q = {q[fps_pkg::ProdW-2:0], 1'b0};
      if (r >= {1'b0, den_r}) begin
        r    = r - {1'b0, den_r};
        q[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = r[fps_pkg::DenW-1:0];
      quo_nxt = q;
      cnt_nxt = cnt_r + CntW'(1);
      if (cnt_r == CntW'(Cycles - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/fps_dpath.sv */
// Datapath of the false-position root search: search state, configuration
// registers, operand preparation, multiplier, divider and output register.
// Uses fps_pkg and fps_div.
module fps_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fps_pkg::cmd_t                  cmd,
  output fps_pkg::sts_t                  sts,
  input  logic                           in_tuser,
  input  logic [fps_pkg::InDataW-1:0]    in_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_index,
  input  logic [fps_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [fps_pkg::OutDataW-1:0]   out_tdata,
  output logic [2:0]                     out_tuser
);

  localparam int W  = fps_pkg::DataW;
  localparam int HW = fps_pkg::XW - W + 1;

  function automatic logic is_pos(input logic [W-1:0] v);
    return !v[W-1] && (v != '0);
  endfunction

  // captured item
  fps_pkg::action_t  act_r;
  logic [W-1:0]      a_in_r, b_in_r, fa_in_r, fb_in_r, fx_in_r;

  // configuration
  logic [fps_pkg::TolW-1:0]  tol_r;
  logic [fps_pkg::IterW-1:0] lim_r;

  // search state
  logic [W-1:0]              bl_r, bl_nxt, br_r, br_nxt;
  logic [W-1:0]              vl_r, vl_nxt, vr_r, vr_nxt;
  logic [W-1:0]              prop_r, prop_nxt;
  logic [fps_pkg::IterW-1:0] iter_r, iter_nxt;
  logic                      srch_r, srch_nxt;

  // arithmetic
  logic [W:0]                ba, den, ba_neg, den_neg;
  logic [W-1:0]              fa_mag, fx_mag;
  logic [W-1:0]              mag_fa_r, mag_ba_r;
  logic [fps_pkg::DenW-1:0]  mag_den_r;
  logic                      qneg_r;
  logic [fps_pkg::ProdW-1:0] prod, quo;
  logic [fps_pkg::XW-1:0]    a_ext, q_ext, x_r;
  logic                      div_done;

  // results
  fps_pkg::status_t          res_code_r;
  logic [W-1:0]              res_point_r;
  logic                      out_valid_r;
  logic [fps_pkg::OutDataW-1:0] out_data_r;
  fps_pkg::status_t          out_code_r;

  // operand magnitudes; two's complement negation gives the right unsigned
  // magnitude even for the most negative value
  assign ba      = {br_r[W-1], br_r} - {bl_r[W-1], bl_r};
  assign den     = {vr_r[W-1], vr_r} - {vl_r[W-1], vl_r};
  assign ba_neg  = -ba;
  assign den_neg = -den;
  assign fa_mag  = vl_r[W-1] ? -vl_r : vl_r;
  assign fx_mag  = fx_in_r[W-1] ? -fx_in_r : fx_in_r;

  assign prod  = mag_fa_r * mag_ba_r;
  assign a_ext = {{(fps_pkg::XW - W){bl_r[W-1]}}, bl_r};
  assign q_ext = {2'b00, quo};

  fps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (mag_den_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    bl_nxt   = bl_r;
    br_nxt   = br_r;
    vl_nxt   = vl_r;
    vr_nxt   = vr_r;
    prop_nxt = prop_r;
    iter_nxt = iter_r;
    srch_nxt = srch_r;
    if (cmd.clr_iter) begin
      iter_nxt = '0;
    end
    if (cmd.load_bracket) begin
      bl_nxt   = a_in_r;
      br_nxt   = b_in_r;
      vl_nxt   = fa_in_r;
      vr_nxt   = fb_in_r;
      prop_nxt = a_in_r;
    end
    if (cmd.update_bracket) begin
      // keep the endpoint whose value has the other sign
      if (is_pos(vl_r) != is_pos(fx_in_r)) begin
        br_nxt = prop_r;
        vr_nxt = fx_in_r;
      end else begin
        bl_nxt = prop_r;
        vl_nxt = fx_in_r;
      end
    end
    if (cmd.finish) begin
      prop_nxt = x_r[W-1:0];
      iter_nxt = iter_r + fps_pkg::IterW'(1);
      srch_nxt = 1'b1;
    end
    if (cmd.stop) begin
      srch_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= fps_pkg::TolResetC;
      lim_r       <= fps_pkg::LimResetC;
      bl_r        <= '0;
      br_r        <= '0;
      vl_r        <= '0;
      vr_r        <= '0;
      prop_r      <= '0;
      iter_r      <= '0;
      srch_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (fps_pkg::cfg_idx_t'(cfg_index))
          fps_pkg::CFG_TOLERANCE:  tol_r <= cfg_data;
          fps_pkg::CFG_ITER_LIMIT: lim_r <= cfg_data[fps_pkg::IterW-1:0];
          default: ;
        endcase
      end
      bl_r   <= bl_nxt;
      br_r   <= br_nxt;
      vl_r   <= vl_nxt;
      vr_r   <= vr_nxt;
      prop_r <= prop_nxt;
      iter_r <= iter_nxt;
      srch_r <= srch_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= fps_pkg::action_t'(in_tuser);
      a_in_r  <= in_tdata[W-1:0];
      b_in_r  <= in_tdata[2*W-1:W];
      fa_in_r <= in_tdata[3*W-1:2*W];
      fb_in_r <= in_tdata[4*W-1:3*W];
      fx_in_r <= in_tdata[5*W-1:4*W];
    end
    if (cmd.prep) begin
      mag_fa_r  <= fa_mag;
      mag_ba_r  <= ba[W] ? ba_neg[W-1:0] : ba[W-1:0];
      mag_den_r <= den[W] ? den_neg : den;
      qneg_r    <= vl_r[W-1] ^ ba[W] ^ den[W];
    end
    if (cmd.calc_x) begin
      x_r <= qneg_r ? a_ext + q_ext : a_ext - q_ext;
    end
    if (cmd.res_load) begin
      res_code_r  <= cmd.res_code;
      res_point_r <= cmd.res_zero ? '0 : prop_nxt;
    end
    if (cmd.emit) begin
      out_data_r <= {iter_r, res_point_r};
      out_code_r <= res_code_r;
    end
  end

  always_comb begin
    sts.is_start  = (act_r == fps_pkg::ACT_START);
    sts.bad_order = $signed(a_in_r) >= $signed(b_in_r);
    sts.no_sign   = is_pos(fa_in_r) == is_pos(fb_in_r);
    sts.searching = srch_r;
    sts.converged = fx_mag < {1'b0, tol_r};
    sts.limit_hit = iter_r >= lim_r;
    sts.den_zero  = (vr_r == vl_r);
    sts.div_done  = div_done;
    sts.overflow  = x_r[fps_pkg::XW-1:W-1] != {HW{x_r[W-1]}};
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_code_r;

endmodule

/* rtl/fps_ctrl.sv */
// Controller of the false-position root search: one-hot sequencer that
// steps the datapath through check, prepare, multiply, divide, new point and result.
// Uses fps_pkg.
module fps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  fps_pkg::sts_t sts,
  output fps_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_CALC  = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_EMIT;
        if (sts.is_start) begin
          cmd.clr_iter = 1'b1;
          if (sts.bad_order) begin
            cmd.res_load = 1'b1;
            cmd.res_code = fps_pkg::ST_BAD_ORDER;
            cmd.res_zero = 1'b1;
            cmd.stop     = 1'b1;
          end else if (sts.no_sign) begin
            cmd.res_load = 1'b1;
            cmd.res_code = fps_pkg::ST_NO_SIGN;
            cmd.res_zero = 1'b1;
            cmd.stop     = 1'b1;
          end else begin
            cmd.load_bracket = 1'b1;
            state_nxt        = S_PREP;
          end
        end else if (!sts.searching) begin
          cmd.res_load = 1'b1;
          cmd.res_code = fps_pkg::ST_IDLE_OVF;
          cmd.res_zero = 1'b1;
        end else if (sts.converged) begin
          cmd.res_load = 1'b1;
          cmd.res_code = fps_pkg::ST_CONVERGED;
          cmd.stop     = 1'b1;
        end else begin
          cmd.update_bracket = 1'b1;
          state_nxt          = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_EMIT;
        if (sts.limit_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_code = fps_pkg::ST_LIMIT;
          cmd.stop     = 1'b1;
        end else if (sts.den_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_code = fps_pkg::ST_ZERO_DEN;
          cmd.stop     = 1'b1;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc_x = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_EMIT;
        if (sts.overflow) begin
          cmd.res_code = fps_pkg::ST_IDLE_OVF;
          cmd.stop     = 1'b1;
        end else begin
          cmd.res_code = fps_pkg::ST_PROPOSE;
          cmd.finish   = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/false_position_root_search.sv */
// False-position root search, Q16.16. An item that ends at the bracket or
// sample check goes from the check to the result; a limit or zero-denominator
// stop passes operand preparation first; a new proposal also passes multiply,
// divide and the new-point step, with the divider making two bits a cycle.
// One item at a time; the next transfer is taken in the cycle after the
// result leaves the sequencer. Reset (rst_n, synchronous) stops any search.
module false_position_root_search (
  input  logic                            clk,
  input  logic                            rst_n,

  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: left[31:0], right[63:32], left_value[95:64],
  //        right_value[127:96], sample_value[159:128]
  input  logic [fps_pkg::InDataW-1:0]     in_tdata,
  // tuser: action (0 start with bracket, 1 function value sample)
  input  logic                            in_tuser,

  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: point[31:0], iteration[47:32]
  output logic [fps_pkg::OutDataW-1:0]    out_tdata,
  // tuser: status
  output logic [2:0]                      out_tuser,

  // configuration writes: index 0 tolerance, index 1 iteration limit
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [fps_pkg::CfgDataW-1:0]    cfg_data
);

  fps_pkg::cmd_t cmd;
  fps_pkg::sts_t sts;

  // Configuration writes go straight into their registers, so the port never pushes back.
  assign cfg_ready = 1'b1;

  // Sequencer: takes one item per search step, drives the datapath through
  // check, operand preparation, multiply, divide, new point and result.
  fps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds the bracket, the last proposed point, the iteration
  // count and the output register. The output register parts the result
  // channel from the sequencer, so a waiting result does not block a new
  // transfer on the input side.
  fps_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // The divider finishes only while the sequencer is busy with a step.
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> !in_tready)
    else $error("divider finished while input was open");

  // A handed-over result shows up on the result channel in the next cycle.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("result lost after hand-over");

  // Every proposal counts at least one point.
  a_propose_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == fps_pkg::ST_PROPOSE))
      |-> (out_tdata[fps_pkg::OutDataW-1:fps_pkg::DataW] != '0))
    else $error("proposal with zero iteration count");

endmodule

/* bench/fps_result_checker.sv */
// Result checker for the false-position root search block.
// Predicts each result from the input and configuration transfers and compares it.
// Depends on fps_pkg.
module fps_result_checker
  import fps_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [InDataW-1:0]         in_tdata,
  input  logic                       in_tuser,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [OutDataW-1:0]        out_tdata,
  input  logic [2:0]                 out_tuser,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data,
  output int                         fail_count,
  output int                         pending,
  output logic signed [DataW-1:0]    last_point,
  output status_t                    last_status
);

  typedef struct packed {
    status_t                  status;
    logic signed [DataW-1:0]  point;
    logic [IterW-1:0]         iteration;
  } root_result_t;

  logic [TolW-1:0]          tol_q;
  logic [IterW-1:0]         limit_q;
  logic signed [DataW-1:0]  lo_x, hi_x, lo_f, hi_f, guess_x;
  logic [IterW-1:0]         iter_q;
  logic                     active_q;
  root_result_t             awaited_results[$];

  function automatic root_result_t make_result(status_t st, logic signed [DataW-1:0] pt);
    root_result_t r;
    r.status    = st;
    r.point     = pt;
    r.iteration = iter_q;
    return r;
  endfunction

  // Next point from the current bracket, or the reason the search ends.
  function automatic root_result_t next_proposal();
    longint                 den, num, quo;
    logic signed [XW-1:0]   x_wide;
    if (iter_q >= limit_q) begin
      active_q = 1'b0;
      return make_result(ST_LIMIT, guess_x);
    end
    den = longint'(hi_f) - longint'(lo_f);
    if (den == 0) begin
      active_q = 1'b0;
      return make_result(ST_ZERO_DEN, guess_x);
    end
    num = longint'(lo_f) * (longint'(hi_x) - longint'(lo_x));
    quo = num / den;
    x_wide = $signed({{(XW-DataW){lo_x[DataW-1]}}, lo_x}) - $signed({{(XW-64){quo[63]}}, quo});
    if (x_wide[XW-1:DataW-1] != {(XW-DataW+1){x_wide[DataW-1]}}) begin
      active_q = 1'b0;
      return make_result(ST_IDLE_OVF, guess_x);
    end
    guess_x  = x_wide[DataW-1:0];
    iter_q   = iter_q + 1'b1;
    active_q = 1'b1;
    return make_result(ST_PROPOSE, guess_x);
  endfunction

  function automatic root_result_t predict_item(logic act_bit, logic [InDataW-1:0] d);
    logic signed [DataW-1:0] a, b, fa, fb, fx;
    longint                  mag;
    a  = d[DataW-1:0];
    b  = d[2*DataW-1:DataW];
    fa = d[3*DataW-1:2*DataW];
    fb = d[4*DataW-1:3*DataW];
    fx = d[5*DataW-1:4*DataW];
    if (action_t'(act_bit) == ACT_START) begin
      iter_q = '0;
      if (a >= b) begin
        active_q = 1'b0;
        return make_result(ST_BAD_ORDER, '0);
      end
      if ((fa > 0) == (fb > 0)) begin
        active_q = 1'b0;
        return make_result(ST_NO_SIGN, '0);
      end
      lo_x    = a;
      hi_x    = b;
      lo_f    = fa;
      hi_f    = fb;
      guess_x = a;
      return next_proposal();
    end
    if (!active_q) return make_result(ST_IDLE_OVF, '0);
    mag = (fx < 0) ? -longint'(fx) : longint'(fx);
    if (mag < longint'(tol_q)) begin
      active_q = 1'b0;
      return make_result(ST_CONVERGED, guess_x);
    end
    if ((lo_f > 0) != (fx > 0)) begin
      hi_x = guess_x;
      hi_f = fx;
    end else begin
      lo_x = guess_x;
      lo_f = fx;
    end
    return next_proposal();
  endfunction

  task automatic flag(string field, longint want, longint got);
    $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    root_result_t want;
    if (!rst_n) begin
      tol_q       = TolResetC;
      limit_q     = LimResetC;
      lo_x        = '0;
      hi_x        = '0;
      lo_f        = '0;
      hi_f        = '0;
      guess_x     = '0;
      iter_q      = '0;
      active_q    = 1'b0;
      fail_count  = 0;
      last_point  = '0;
      last_status = ST_IDLE_OVF;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index) == CFG_TOLERANCE) tol_q = cfg_data[TolW-1:0];
        else limit_q = cfg_data[IterW-1:0];
      end
      // compare before pushing, so a stray result never pairs with a fresh item
      if (out_tvalid && out_tready) begin
        last_point  = out_tdata[DataW-1:0];
        last_status = status_t'(out_tuser);
        if (awaited_results.size() == 0) begin
          flag("unexpected result, status", -1, longint'(out_tuser));
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser !== want.status)
            flag("status", longint'(want.status), longint'(out_tuser));
          if (out_tdata[DataW-1:0] !== want.point)
            flag("point", longint'(want.point), longint'($signed(out_tdata[DataW-1:0])));
          if (out_tdata[DataW+IterW-1:DataW] !== want.iteration)
            flag("iteration", longint'(want.iteration),
                 longint'(out_tdata[DataW+IterW-1:DataW]));
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(predict_item(in_tuser, in_tdata));
    end
    pending = awaited_results.size();
  end

endmodule

/* bench/tb_false_position_root_search.sv */
// Testbench top for the false-position root search block: clock, reset, stimulus, verdict.
// Checking is done by fps_result_checker, instantiated beside the block.
// Depends on fps_pkg, false_position_root_search and fps_result_checker.
module tb_false_position_root_search;
  import fps_pkg::*;

  localparam int CycleLimit    = 1_000_000;
  localparam int ItemsPerPhase = 135;
  localparam int SettleCycles  = 60;     // wait after the last result before the verdict
  localparam int NumPhases     = 8;

  localparam logic [DataW-1:0] OneQ    = 32'h0001_0000;
  localparam logic [DataW-1:0] MinQ    = 32'h8000_0000;
  localparam logic [DataW-1:0] MaxQ    = 32'h7FFF_FFFF;
  localparam longint           MinQ64  = -64'sd2147483648;
  localparam longint           MaxQ64  = 64'sd2147483647;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  // tdata: left, right, left_value, right_value, sample_value (32 bits each, from bit 0)
  logic [InDataW-1:0]         in_tdata;
  // tuser: action
  logic                       in_tuser;
  logic                       out_tvalid;
  logic                       out_tready;
  // tdata: point[31:0], iteration[47:32]
  logic [OutDataW-1:0]        out_tdata;
  // tuser: status
  logic [2:0]                 out_tuser;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic                       cfg_index;
  logic [CfgDataW-1:0]        cfg_data;

  int                         fail_count;
  int                         pending;
  logic signed [DataW-1:0]    last_point;
  status_t                    last_status;

  int                         send_idle_pct;
  int                         recv_stall_pct;
  int                         items_sent;
  int                         cycle_count;

  // test function f(x) = slope*(x-root) + bend*(x-root)^2, Q16.16, saturated
  longint                     curve_root;
  longint                     curve_slope;
  longint                     curve_bend;

  // tolerance and limit per random phase; the largest and smallest nonzero values are in here
  int unsigned                tol_set [NumPhases] = '{16, 1, 32'h7FFF_FFFF, 4096,
                                                      256, 1, 65535, 2};
  int unsigned                lim_set [NumPhases] = '{100, 65535, 3, 1, 12, 40, 65535, 7};

  false_position_root_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fps_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .last_point  (last_point),
    .last_status (last_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: stall at random per cycle while the phase asks for it.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer; leave valid high on return so a
  // following item can go back to back.
  task automatic put_item(action_t act, logic [DataW-1:0] left, logic [DataW-1:0] right,
                          logic [DataW-1:0] lval, logic [DataW-1:0] rval,
                          logic [DataW-1:0] sval);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {sval, rval, lval, right, left};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and hold off until every expected result has arrived.
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic put_and_wait(action_t act, logic [DataW-1:0] left, logic [DataW-1:0] right,
                              logic [DataW-1:0] lval, logic [DataW-1:0] rval,
                              logic [DataW-1:0] sval);
    put_item(act, left, right, lval, rval, sval);
    wait_results_done();
  endtask

  // Only called with the block idle.
  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [DataW-1:0] curve_at(logic signed [DataW-1:0] x);
    longint d, y;
    d = longint'(x) - curve_root;
    y = ((d * curve_slope) >>> 16) + curve_bend * ((d * d) >>> 32);
    if (y > MaxQ64) return MaxQ;
    if (y < MinQ64) return MinQ;
    return y[DataW-1:0];
  endfunction

  // A well-formed search: bracket a root of a fresh test function, then answer each
  // proposal with the function value there until the block stops or the cap is hit.
  task automatic tracked_search();
    longint           a, b;
    int               steps, cap;
    logic [DataW-1:0] sv;
    if ($urandom_range(9) == 0) begin
      // wide bracket, linear only so the square term cannot wrap
      curve_root = longint'($signed($urandom())) >>> 2;
      a = curve_root - longint'($urandom_range(1, 32'h7FFF_FFFF));
      b = curve_root + longint'($urandom_range(1, 32'h7FFF_FFFF));
      curve_bend = 0;
    end else begin
      curve_root = longint'($urandom_range(0, 1 << 25)) - (64'sd1 << 24);
      a = curve_root - longint'($urandom_range(1, 1 << 24));
      b = curve_root + longint'($urandom_range(1, 1 << 24));
      curve_bend = longint'($urandom_range(0, 6)) - 3;
    end
    if (a < MinQ64) a = MinQ64;
    if (b > MaxQ64) b = MaxQ64;
    curve_slope = longint'($urandom_range(1, 1 << 20));
    if ($urandom_range(1) == 1) curve_slope = -curve_slope;
    put_and_wait(ACT_START, a[DataW-1:0], b[DataW-1:0], curve_at(a[DataW-1:0]),
                 curve_at(b[DataW-1:0]), $urandom());
    cap   = $urandom_range(2, 40);
    steps = 0;
    while (last_status == ST_PROPOSE && steps < cap) begin
      // now and then answer with noise instead of the true value
      sv = ($urandom_range(19) == 0) ? $urandom() : curve_at(last_point);
      put_and_wait(ACT_SAMPLE, $urandom(), $urandom(), $urandom(), $urandom(), sv);
      steps++;
    end
    // one more sample: idle report if the search ended, otherwise a further step
    if ($urandom_range(3) == 0)
      put_and_wait(ACT_SAMPLE, $urandom(), $urandom(), $urandom(), $urandom(),
                   curve_at(last_point));
  endtask

  // Back-to-back items with random content, some shaped into proper brackets.
  task automatic blind_items(int count);
    logic [DataW-1:0] a, b, fa, fb, sv, swap;
    action_t          act;
    repeat (count) begin
      a  = $urandom();
      b  = $urandom();
      fa = $urandom();
      fb = $urandom();
      sv = $urandom();
      if ($urandom_range(1) == 1) begin
        if ($signed(a) > $signed(b)) begin
          swap = a;
          a    = b;
          b    = swap;
        end
        fa[DataW-1] = ~fb[DataW-1];
      end
      if ($urandom_range(3) == 0) sv = $urandom_range(0, 8) - 4;
      act = ($urandom_range(2) == 0) ? ACT_START : ACT_SAMPLE;
      put_item(act, a, b, fa, fb, sv);
    end
  endtask

  initial begin
    int target;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = 1'b0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    curve_root     = 0;
    curve_slope    = 1;
    curve_bend     = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, run one item at a time with no idling.
    write_reg(CFG_TOLERANCE, 31'd1);
    write_reg(CFG_ITER_LIMIT, 31'd100);
    // sample with no search running
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, MaxQ);
    // bad order: equal endpoints, then extremes reversed
    put_and_wait(ACT_START, 5 * OneQ, 5 * OneQ, -OneQ, OneQ, '0);
    put_and_wait(ACT_START, MaxQ, MinQ, -OneQ, OneQ, '0);
    // no sign change: both zero, both negative, both positive
    put_and_wait(ACT_START, '0, OneQ, '0, '0, '0);
    put_and_wait(ACT_START, '0, OneQ, MinQ, 32'hFFFF_FFFF, '0);
    put_and_wait(ACT_START, '0, OneQ, 32'd1, MaxQ, '0);
    // zero value on the left proposes the left endpoint, then a zero sample converges
    put_and_wait(ACT_START, -2 * OneQ, 3 * OneQ, '0, 32'd1, '0);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, '0);
    // widest bracket and extreme values
    put_and_wait(ACT_START, MinQ, MaxQ, MinQ, MaxQ, '0);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, MinQ);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, MaxQ);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, 32'd1);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, 32'hFFFF_FFFF);
    // zero tolerance never converges, not even on a zero sample
    write_reg(CFG_TOLERANCE, 31'd0);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, '0);
    // zero limit stops the search at the start; the next sample finds it idle
    write_reg(CFG_ITER_LIMIT, 31'd0);
    put_and_wait(ACT_START, -OneQ, OneQ, -OneQ, OneQ, '0);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, 32'd3);
    // upper data bits are dropped for the limit register
    write_reg(CFG_ITER_LIMIT, 31'h7FFF_0002);
    write_reg(CFG_TOLERANCE, 31'h7FFF_FFFF);
    put_and_wait(ACT_START, '0, 4 * OneQ, -3 * OneQ, 5 * OneQ, '0);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, MinQ);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, 32'd5);
    // run into the iteration limit, then sample while idle
    write_reg(CFG_TOLERANCE, 31'd1);
    put_and_wait(ACT_START, '0, 4 * OneQ, -3 * OneQ, 5 * OneQ, '0);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, 7 * OneQ);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, 3 * OneQ);
    put_and_wait(ACT_SAMPLE, '0, '0, '0, '0, '0);

    // Random part: each phase takes a new setting and a new idling pattern.
    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_results_done();
      write_reg(CFG_TOLERANCE, CfgDataW'(tol_set[phase]));
      write_reg(CFG_ITER_LIMIT, {15'($urandom_range(0, 32'h7FFF)), 16'(lim_set[phase])});
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) begin
        if ($urandom_range(3) != 0) tracked_search();
        else blind_items($urandom_range(1, 6));
      end
    end

    wait_results_done();
    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
